FILE: sv/keyboard_decimal_entry_core_defines.svh
// Assertion macros for the keyboard decimal entry modules, used by kde_entry.
`ifndef KEYBOARD_DECIMAL_ENTRY_CORE_DEFINES_SVH
`define KEYBOARD_DECIMAL_ENTRY_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyboard decimal entry: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyboard decimal entry: next-cycle check failed");

`endif

FILE: sv/kde_pkg.sv
`default_nettype none

package kde_pkg;

    localparam int unsigned KDE_CODE_W     = 8;
    localparam int unsigned KDE_ROW_W      = 5;
    localparam int unsigned KDE_COL_W      = 7;
    localparam int unsigned KDE_CHAR_W     = 8;
    localparam int unsigned KDE_ADDR_W     = 12;
    localparam int unsigned KDE_VALUE_W    = 32;
    localparam int unsigned KDE_COUNT_W    = 4;
    localparam int unsigned KDE_DIGIT_W    = 4;
    localparam int unsigned KDE_CFG_DATA_W = 7;
    localparam int unsigned KDE_CFG_IDX_W  = 1;

    // Entry ends when this many slots have been used.
    localparam int unsigned KDE_MAX_SLOTS      = 10;
    // Text cells per screen row.
    localparam int unsigned KDE_SCREEN_COLUMNS = 80;

    localparam logic [KDE_COL_W-1:0] KDE_START_COLUMN_RESET = KDE_COL_W'(10);

    // Configuration register indexes.
    typedef enum logic [KDE_CFG_IDX_W-1:0] {
        CFG_TEXT_ROW     = 1'b0,
        CFG_START_COLUMN = 1'b1
    } t_cfg_index;

    // One result transaction.
    typedef struct packed {
        logic                   echo_valid;
        logic [KDE_CHAR_W-1:0]  echo_char;
        logic [KDE_ADDR_W-1:0]  echo_address;
        logic                   entry_done;
        logic [KDE_VALUE_W-1:0] entered_value;
    } t_kde_result;

endpackage

`default_nettype wire

FILE: sv/keyboard_decimal_entry_core.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// in        input      i_in_valid/o_in_stall  i_scan_code
// out       output     o_out_valid/i_out_stall o_echo_*, o_entry_done, o_entered_value
// cfg       input      i_cfg_wr_en            i_cfg_index, i_cfg_data
//
// Every scan code that is taken yields one result transaction: the byte is
// held in the input register, then passes through the step logic into the
// result register. A new byte can be taken every cycle while o_in_stall is low.
// Reset (synchronous, active low) clears the entry state and both valid flags,
// and sets the row to 0 and the start column to 10.
// A stall on the output holds the result register; the input register then
// fills and o_in_stall rises in the same cycle.

module keyboard_decimal_entry_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [kde_pkg::KDE_CODE_W-1:0]     i_scan_code,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_echo_valid,
    output logic [kde_pkg::KDE_CHAR_W-1:0]          o_echo_char,
    output logic [kde_pkg::KDE_ADDR_W-1:0]          o_echo_address,
    output logic                                    o_entry_done,
    output logic [kde_pkg::KDE_VALUE_W-1:0]         o_entered_value,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [kde_pkg::KDE_CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [kde_pkg::KDE_CFG_DATA_W-1:0] i_cfg_data
);
    import kde_pkg::*;

    // Config regs: the user must change them only while the block is idle; not enforced.
    logic [KDE_ROW_W-1:0] r_text_row;
    logic [KDE_COL_W-1:0] r_start_column;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_row     <= '0;
            r_start_column <= KDE_START_COLUMN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TEXT_ROW:     r_text_row     <= i_cfg_data[KDE_ROW_W-1:0];
                CFG_START_COLUMN: r_start_column <= i_cfg_data[KDE_COL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input register. A held byte moves on whenever the result register is
    // empty or is being read out in this cycle.
    logic                  r_in_valid;
    logic [KDE_CODE_W-1:0] r_in_code;
    logic                  out_valid;
    logic                  advance;
    logic                  in_take;
    t_kde_result           step_result;
    t_kde_result           out_result;

    assign advance    = r_in_valid && (!out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_code <= i_scan_code;
        end
    end

    // The entry state advances exactly when its result is loaded.
    kde_entry u_entry (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_code         (r_in_code),
        .i_text_row     (r_text_row),
        .i_start_column (r_start_column),
        .o_result       (step_result)
    );

    kde_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_result    (step_result),
        .i_out_stall (i_out_stall),
        .o_out_valid (out_valid),
        .o_result    (out_result)
    );

    assign o_out_valid     = out_valid;
    assign o_echo_valid    = out_result.echo_valid;
    assign o_echo_char     = out_result.echo_char;
    assign o_echo_address  = out_result.echo_address;
    assign o_entry_done    = out_result.entry_done;
    assign o_entered_value = out_result.entered_value;

endmodule

`default_nettype wire

FILE: sv/kde_entry.sv
`default_nettype none
`include "keyboard_decimal_entry_core_defines.svh"

// Entry state and the per-byte step: break skipping, digit decode, echo
// address, accumulation and slot counting.
module kde_entry (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [kde_pkg::KDE_CODE_W-1:0] i_code,
    input  wire logic [kde_pkg::KDE_ROW_W-1:0]  i_text_row,
    input  wire logic [kde_pkg::KDE_COL_W-1:0]  i_start_column,
    output kde_pkg::t_kde_result               o_result
);
    import kde_pkg::*;

    localparam logic [KDE_CODE_W-1:0]  CODE_BREAK = KDE_CODE_W'(240);
    localparam logic [KDE_CODE_W-1:0]  CODE_ENTER = KDE_CODE_W'(90);
    localparam logic [KDE_CHAR_W-1:0]  CHAR_ZERO  = KDE_CHAR_W'(48);
    localparam logic [KDE_COUNT_W-1:0] SLOT_LIMIT = KDE_COUNT_W'(KDE_MAX_SLOTS);
    localparam logic [KDE_ADDR_W-1:0]  ROW_PITCH  = KDE_ADDR_W'(KDE_SCREEN_COLUMNS);

    logic                   r_break_pending, n_break_pending;
    logic [KDE_COUNT_W-1:0] r_slots_used, n_slots_used;
    logic [KDE_COUNT_W-1:0] r_digits_typed, n_digits_typed;
    logic [KDE_VALUE_W-1:0] r_running_value, n_running_value;

    logic                   is_digit;
    logic [KDE_DIGIT_W-1:0] digit;
    t_kde_result            result;

    // Set-2 make codes of the main-row digit keys.
    always_comb begin
        is_digit = 1'b1;
        digit    = '0;
        unique case (i_code)
            KDE_CODE_W'(69): digit = KDE_DIGIT_W'(0);
            KDE_CODE_W'(22): digit = KDE_DIGIT_W'(1);
            KDE_CODE_W'(30): digit = KDE_DIGIT_W'(2);
            KDE_CODE_W'(38): digit = KDE_DIGIT_W'(3);
            KDE_CODE_W'(37): digit = KDE_DIGIT_W'(4);
            KDE_CODE_W'(46): digit = KDE_DIGIT_W'(5);
            KDE_CODE_W'(54): digit = KDE_DIGIT_W'(6);
            KDE_CODE_W'(61): digit = KDE_DIGIT_W'(7);
            KDE_CODE_W'(62): digit = KDE_DIGIT_W'(8);
            KDE_CODE_W'(70): digit = KDE_DIGIT_W'(9);
            default:         is_digit = 1'b0;
        endcase
    end

    always_comb begin
        n_break_pending = r_break_pending;
        n_slots_used    = r_slots_used;
        n_digits_typed  = r_digits_typed;
        n_running_value = r_running_value;
        result          = '0;

        if (r_break_pending) begin
            n_break_pending = 1'b0;
        end else if (i_code == CODE_BREAK) begin
            n_break_pending = 1'b1;
        end else if (i_code == CODE_ENTER) begin
            result.entry_done = 1'b1;
        end else begin
            if (is_digit) begin
                result.echo_valid   = 1'b1;
                result.echo_char    = CHAR_ZERO + KDE_CHAR_W'(digit);
                result.echo_address = KDE_ADDR_W'(i_text_row) * ROW_PITCH
                                    + KDE_ADDR_W'(i_start_column)
                                    + KDE_ADDR_W'(r_digits_typed);
                // value * 10 as two shifts and an add.
                n_running_value = (r_running_value << 3) + (r_running_value << 1)
                                + KDE_VALUE_W'(digit);
                n_digits_typed  = r_digits_typed + KDE_COUNT_W'(1);
            end
            n_slots_used = r_slots_used + KDE_COUNT_W'(1);
            if (n_slots_used >= SLOT_LIMIT) begin
                result.entry_done = 1'b1;
            end
        end

        if (result.entry_done) begin
            result.entered_value = n_running_value;
            n_break_pending      = 1'b0;
            n_slots_used         = '0;
            n_digits_typed       = '0;
            n_running_value      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_pending <= 1'b0;
            r_slots_used    <= '0;
            r_digits_typed  <= '0;
            r_running_value <= '0;
        end else if (i_step) begin
            r_break_pending <= n_break_pending;
            r_slots_used    <= n_slots_used;
            r_digits_typed  <= n_digits_typed;
            r_running_value <= n_running_value;
        end
    end

    assign o_result = result;

    `KDE_ASSERT_NOW(a_slots_below_limit, i_clk, i_rst_n, 1'b1, r_slots_used < SLOT_LIMIT)
    `KDE_ASSERT_NOW(a_digits_within_slots, i_clk, i_rst_n, 1'b1, r_digits_typed <= r_slots_used)
    `KDE_ASSERT_NOW(a_no_echo_after_break, i_clk, i_rst_n, r_break_pending, !result.echo_valid && !result.entry_done)
    `KDE_ASSERT_NEXT(a_done_clears_entry, i_clk, i_rst_n, i_step && result.entry_done, r_slots_used == '0 && r_running_value == '0 && !r_break_pending)

endmodule

`default_nettype wire

FILE: sv/kde_out_reg.sv
`default_nettype none

// Result register: loads a new result on i_load, which the core raises only when the
// slot is free or being emptied, and holds it while the consumer stalls.
module kde_out_reg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  kde_pkg::t_kde_result      i_result,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output kde_pkg::t_kde_result      o_result
);
    import kde_pkg::*;

    logic        r_valid;
    t_kde_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire
